>>> rtl/elgamal_byte_verifier_top_assert.svh
// Assertion macros shared by the verifier modules.
// Depends on nothing; included by modules that check their own logic.
`ifndef ELGAMAL_BYTE_VERIFIER_TOP_ASSERT_SVH
`define ELGAMAL_BYTE_VERIFIER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define EBV_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Implication whose consequence is checked in the cycle after the antecedent.
`define EBV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

>>> rtl/ebv_pkg.sv
// Package for the byte-wise signature verifier: widths, payload types, states.
// Depends on nothing; used by every module of the block.
package ebv_pkg;
   localparam int unsigned ModBits     = 32;
   localparam int unsigned DigestBytes = 32;
   localparam int unsigned CountBits   = 6;
   localparam int unsigned MulCntBits  = $clog2(ModBits + 1);
   localparam logic [CountBits-1:0] CountMax = 6'd63;
   localparam logic [ModBits-1:0] ModulusReset   = 32'd30803;
   localparam logic [ModBits-1:0] GeneratorReset = 32'd2;
   localparam logic [ModBits-1:0] PublicReset    = 32'd1;
   localparam logic [1:0] RegModulus   = 2'd0;
   localparam logic [1:0] RegGenerator = 2'd1;
   localparam logic [1:0] RegPublic    = 2'd2;

   typedef struct packed {
      logic [7:0]         digest_byte;
      logic [ModBits-1:0] sig_r;
      logic [ModBits-1:0] sig_s;
      logic               last_pair;
   } req_payload_type;

   typedef struct packed {
      logic pair_ok;
      logic all_ok;
      logic final_res;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_RUN,
      MUL_DONE
   } mul_state_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_START,
      SEQ_G_RED,
      SEQ_LHS_MUL,
      SEQ_LHS_SQR,
      SEQ_Y_RED,
      SEQ_Y_MUL,
      SEQ_Y_SQR,
      SEQ_R_MUL,
      SEQ_R_SQR,
      SEQ_FINAL,
      SEQ_OUT
   } seq_state_type;

   // Request and answer between the sequencer and the multiplier.
   typedef struct packed {
      logic               start;
      logic [ModBits-1:0] a;
      logic [ModBits-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic [ModBits-1:0] product;
   } mul_rsp_type;
endpackage

>>> rtl/elgamal_byte_verifier_top.sv
// Top level of the byte-wise signature verifier: key registers and sequencer.
// Depends on ebv_pkg and ebv_seq.
//
// Use: write modulus, generator and public value over the csr_ port
// (byte addresses 0, 4, 8) while the block is idle; reads return them.
// Each req_ transfer carries one digest byte, its pair (r,s) and a last mark.
// One rsp_ transfer follows per request with the pair verdict, the running
// verdict and the end-of-message flag.
// Timing: a pair out of range goes from its transfer through the start and output
// states to the result register. Otherwise the generator is reduced and its
// exponentiation runs, then the public value is reduced and two more follow; each
// takes one multiply and one square per exponent bit on the shared bit-serial
// multiplier, and a final multiply ends the check. One item is in work at a time,
// and the next request is taken in the cycle after a result is loaded.
// Reset restores the key reset values, clears the pair count and sets the
// running verdict. While the receiver stalls, the result waits in its register;
// the next item is taken and worked on, but its result is held until that
// register is free, and no further request is taken meanwhile.
module elgamal_byte_verifier_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ebv_pkg::req_payload_type          req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ebv_pkg::rsp_payload_type          rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [3:0]                        paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   logic [ebv_pkg::ModBits-1:0] mod_ff, gen_ff, pub_ff;
   logic                        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // Key register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= ebv_pkg::ModulusReset;
         gen_ff <= ebv_pkg::GeneratorReset;
         pub_ff <= ebv_pkg::PublicReset;
      end else if (wr_en && paddr[1:0] == 2'b00) begin
         if (paddr[3:2] == ebv_pkg::RegModulus)   mod_ff <= pwdata;
         if (paddr[3:2] == ebv_pkg::RegGenerator) gen_ff <= pwdata;
         if (paddr[3:2] == ebv_pkg::RegPublic)    pub_ff <= pwdata;
      end
   end

   // Register read-back.
   always_comb begin
      unique case (paddr[3:2])
         ebv_pkg::RegModulus:   prdata = mod_ff;
         ebv_pkg::RegGenerator: prdata = gen_ff;
         ebv_pkg::RegPublic:    prdata = pub_ff;
         default:               prdata = '0;
      endcase
   end

   ebv_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .modulus      (mod_ff),
      .generator    (gen_ff),
      .public_value (pub_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );
endmodule

>>> rtl/ebv_modmul.sv
// Bit-serial modular multiplier: (a*b) mod p, one bit of b per cycle.
// Depends on ebv_pkg and the assertion macro header.
`include "elgamal_byte_verifier_top_assert.svh"
module ebv_modmul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [ebv_pkg::ModBits-1:0]         modulus,
   input  ebv_pkg::mul_req_type                mul_req,
   output ebv_pkg::mul_rsp_type                mul_rsp
);
   ebv_pkg::mul_state_type state_ff, state_in;
   logic [ebv_pkg::ModBits-1:0] acc_ff, acc_in;
   logic [ebv_pkg::ModBits-1:0] mcand_ff, mcand_in;
   logic [ebv_pkg::ModBits-1:0] mplier_ff, mplier_in;
   logic [ebv_pkg::MulCntBits-1:0] cnt_ff, cnt_in;
   logic [ebv_pkg::ModBits:0]   dbl, dbl_red, add_sum;
   logic [ebv_pkg::ModBits-1:0] acc_step;

   // Double then conditionally add; each value stays below p.
   always_comb begin
      dbl      = {acc_ff, 1'b0};
      dbl_red  = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
      add_sum  = dbl_red + {1'b0, mcand_ff};
      if (mplier_ff[ebv_pkg::ModBits-1]) begin
         acc_step = (add_sum >= {1'b0, modulus}) ?
                    ebv_pkg::ModBits'(add_sum - {1'b0, modulus}) :
                    ebv_pkg::ModBits'(add_sum);
      end else begin
         acc_step = ebv_pkg::ModBits'(dbl_red);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ebv_pkg::MUL_IDLE: if (mul_req.start) state_in = ebv_pkg::MUL_RUN;
         ebv_pkg::MUL_RUN:  if (cnt_ff == ebv_pkg::MulCntBits'(1)) state_in = ebv_pkg::MUL_DONE;
         ebv_pkg::MUL_DONE: state_in = ebv_pkg::MUL_IDLE;
         default:           state_in = ebv_pkg::MUL_IDLE;
      endcase
   end

   // Datapath updates.
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         ebv_pkg::MUL_IDLE: begin
            acc_in    = '0;
            mcand_in  = mul_req.a;
            mplier_in = mul_req.b;
            cnt_in    = ebv_pkg::MulCntBits'(ebv_pkg::ModBits);
         end
         ebv_pkg::MUL_RUN: begin
            acc_in    = acc_step;
            mplier_in = {mplier_ff[ebv_pkg::ModBits-2:0], 1'b0};
            cnt_in    = cnt_ff - ebv_pkg::MulCntBits'(1);
         end
         default: ;
      endcase
   end

   // Outputs.
   always_comb begin
      mul_rsp.done    = (state_ff == ebv_pkg::MUL_DONE);
      mul_rsp.product = acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ebv_pkg::MUL_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   `EBV_ASSERT_IMP(a_acc_reduced, clock, reset, state_ff == ebv_pkg::MUL_DONE, acc_ff < modulus)
   `EBV_ASSERT_NEXT(a_done_once, clock, reset, state_ff == ebv_pkg::MUL_DONE, !mul_rsp.done)
   `EBV_ASSERT_IMP(a_cnt_live, clock, reset, state_ff == ebv_pkg::MUL_RUN, cnt_ff != '0)
endmodule

>>> rtl/ebv_seq.sv
// Sequencer: three square-and-multiply exponentiations and the final check.
// Depends on ebv_pkg, ebv_modmul and the assertion macro header.
`include "elgamal_byte_verifier_top_assert.svh"
module ebv_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [ebv_pkg::ModBits-1:0]       modulus,
   input  logic [ebv_pkg::ModBits-1:0]       generator,
   input  logic [ebv_pkg::ModBits-1:0]       public_value,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ebv_pkg::req_payload_type          req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ebv_pkg::rsp_payload_type          rsp_data
);
   ebv_pkg::seq_state_type state_ff, state_in;
   ebv_pkg::req_payload_type item_ff, item_in;
   logic [ebv_pkg::ModBits-1:0] base_ff, base_in, acc_ff, acc_in, exp_ff, exp_in;
   logic [ebv_pkg::ModBits-1:0] lhs_ff, lhs_in, yr_ff, yr_in;
   logic         ok_ff, ok_in;
   logic [ebv_pkg::CountBits-1:0] count_ff, count_in;
   logic         run_ff, run_in;
   logic         rv_ff, rv_in;
   ebv_pkg::rsp_payload_type out_ff, out_in;
   ebv_pkg::mul_req_type mreq;
   ebv_pkg::mul_rsp_type mrsp;
   logic         in_range, mul_phase, sqr_phase, red_phase, exp_last, fin_ok, all_v;
   logic [ebv_pkg::CountBits-1:0] count_inc;

   ebv_modmul u_mul (
      .clock   (clock),
      .reset   (reset),
      .modulus (modulus),
      .mul_req (mreq),
      .mul_rsp (mrsp)
   );

   assign in_range = (modulus >= ebv_pkg::ModBits'(3)) && (item_ff.sig_r != '0) &&
                     (item_ff.sig_r < modulus) && (item_ff.sig_s != '0) &&
                     (item_ff.sig_s < modulus - ebv_pkg::ModBits'(1));
   assign mul_phase = (state_ff == ebv_pkg::SEQ_LHS_MUL) || (state_ff == ebv_pkg::SEQ_Y_MUL) ||
                      (state_ff == ebv_pkg::SEQ_R_MUL) || (state_ff == ebv_pkg::SEQ_FINAL);
   assign sqr_phase = (state_ff == ebv_pkg::SEQ_LHS_SQR) || (state_ff == ebv_pkg::SEQ_Y_SQR) ||
                      (state_ff == ebv_pkg::SEQ_R_SQR);
   assign red_phase = (state_ff == ebv_pkg::SEQ_G_RED) || (state_ff == ebv_pkg::SEQ_Y_RED);
   // The exponent is used up once no bit remains above the one just consumed.
   assign exp_last  = (exp_ff[ebv_pkg::ModBits-1:1] == '0);
   assign fin_ok    = (mrsp.product == lhs_ff);
   assign count_inc = (count_ff < ebv_pkg::CountMax) ? count_ff + 1'b1 : count_ff;

   // Multiplier request: multiply step is acc*base, square step is base*base.
   // A key value is brought below p by multiplying it by one.
   always_comb begin
      mreq.a     = sqr_phase ? base_ff : acc_ff;
      mreq.b     = base_ff;
      mreq.start = 1'b0;
      if (state_ff == ebv_pkg::SEQ_G_RED) mreq.b = generator;
      if (state_ff == ebv_pkg::SEQ_Y_RED) mreq.b = public_value;
      if (state_ff == ebv_pkg::SEQ_FINAL) begin
         mreq.a = yr_ff;
         mreq.b = acc_ff;
      end
      if ((mul_phase || sqr_phase || red_phase) && !mrsp.done) mreq.start = 1'b1;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ebv_pkg::SEQ_IDLE: if (req_valid) state_in = ebv_pkg::SEQ_START;
         ebv_pkg::SEQ_START: state_in = in_range ? ebv_pkg::SEQ_G_RED : ebv_pkg::SEQ_OUT;
         ebv_pkg::SEQ_G_RED: if (mrsp.done) state_in = ebv_pkg::SEQ_LHS_MUL;
         ebv_pkg::SEQ_LHS_MUL: if (mrsp.done) state_in = ebv_pkg::SEQ_LHS_SQR;
         ebv_pkg::SEQ_LHS_SQR: if (mrsp.done) state_in = exp_last ? ebv_pkg::SEQ_Y_RED
                                                                   : ebv_pkg::SEQ_LHS_MUL;
         ebv_pkg::SEQ_Y_RED: if (mrsp.done) state_in = ebv_pkg::SEQ_Y_MUL;
         ebv_pkg::SEQ_Y_MUL: if (mrsp.done) state_in = ebv_pkg::SEQ_Y_SQR;
         ebv_pkg::SEQ_Y_SQR: if (mrsp.done) state_in = exp_last ? ebv_pkg::SEQ_R_MUL
                                                                 : ebv_pkg::SEQ_Y_MUL;
         ebv_pkg::SEQ_R_MUL: if (mrsp.done) state_in = ebv_pkg::SEQ_R_SQR;
         ebv_pkg::SEQ_R_SQR: if (mrsp.done) state_in = exp_last ? ebv_pkg::SEQ_FINAL
                                                                 : ebv_pkg::SEQ_R_MUL;
         ebv_pkg::SEQ_FINAL: if (mrsp.done) state_in = ebv_pkg::SEQ_OUT;
         ebv_pkg::SEQ_OUT: if (!rv_ff || rsp_ready) state_in = ebv_pkg::SEQ_IDLE;
         default: state_in = ebv_pkg::SEQ_IDLE;
      endcase
   end

   // Datapath and verdict bookkeeping.
   always_comb begin
      item_in  = item_ff;
      base_in  = base_ff;
      acc_in   = acc_ff;
      exp_in   = exp_ff;
      lhs_in   = lhs_ff;
      yr_in    = yr_ff;
      ok_in    = ok_ff;
      count_in = count_ff;
      run_in   = run_ff;
      rv_in    = rv_ff;
      out_in   = out_ff;
      all_v    = run_ff && ok_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         ebv_pkg::SEQ_IDLE: begin
            if (req_valid) item_in = req_data;
         end
         ebv_pkg::SEQ_START: begin
            ok_in   = 1'b0;
            acc_in  = ebv_pkg::ModBits'(1);
            exp_in  = ebv_pkg::ModBits'(item_ff.digest_byte);
         end
         ebv_pkg::SEQ_G_RED, ebv_pkg::SEQ_Y_RED: begin
            if (mrsp.done) base_in = mrsp.product;
         end
         ebv_pkg::SEQ_LHS_MUL, ebv_pkg::SEQ_Y_MUL, ebv_pkg::SEQ_R_MUL: begin
            if (mrsp.done && exp_ff[0]) acc_in = mrsp.product;
         end
         ebv_pkg::SEQ_LHS_SQR, ebv_pkg::SEQ_Y_SQR, ebv_pkg::SEQ_R_SQR: begin
            if (mrsp.done) begin
               base_in = mrsp.product;
               exp_in  = exp_ff >> 1;
               if (exp_last) begin
                  // Exponent used up: store this power, load the next one.
                  acc_in = ebv_pkg::ModBits'(1);
                  unique case (state_ff)
                     ebv_pkg::SEQ_LHS_SQR: begin
                        lhs_in  = acc_ff;
                        exp_in  = item_ff.sig_r;
                     end
                     ebv_pkg::SEQ_Y_SQR: begin
                        yr_in   = acc_ff;
                        base_in = item_ff.sig_r;
                        exp_in  = item_ff.sig_s;
                     end
                     default: acc_in = acc_ff;
                  endcase
               end
            end
         end
         ebv_pkg::SEQ_FINAL: begin
            if (mrsp.done) ok_in = fin_ok;
         end
         ebv_pkg::SEQ_OUT: begin
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1;
               out_in.pair_ok   = ok_ff;
               out_in.final_res = item_ff.last_pair;
               if (item_ff.last_pair) begin
                  out_in.all_ok = all_v &&
                     (count_inc == ebv_pkg::CountBits'(ebv_pkg::DigestBytes));
                  count_in = '0;
                  run_in   = 1'b1;
               end else begin
                  out_in.all_ok = all_v;
                  count_in = count_inc;
                  run_in   = all_v;
               end
            end
         end
         default: ;
      endcase
   end

   assign req_ready = (state_ff == ebv_pkg::SEQ_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ebv_pkg::SEQ_IDLE;
         count_ff <= '0;
         run_ff   <= 1'b1;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         run_ff   <= run_in;
         rv_ff    <= rv_in;
      end
      item_ff <= item_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
      exp_ff  <= exp_in;
      lhs_ff  <= lhs_in;
      yr_ff   <= yr_in;
      ok_ff   <= ok_in;
      out_ff  <= out_in;
   end

   `EBV_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == ebv_pkg::SEQ_IDLE)
   `EBV_ASSERT_NEXT(a_out_loads, clock, reset, state_ff == ebv_pkg::SEQ_OUT && state_in == ebv_pkg::SEQ_IDLE, rsp_valid)
   `EBV_ASSERT_IMP(a_pass_range, clock, reset, rsp_valid && rsp_data.all_ok, rsp_data.pair_ok)
endmodule

>>> verif/elgamal_byte_verifier_checker.sv
// Checker for the byte-wise signature verifier: models the key registers and the
// verdict state, predicts each response and compares it. Depends on ebv_pkg.
`timescale 1ns / 1ps
module elgamal_byte_verifier_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  ebv_pkg::req_payload_type req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  ebv_pkg::rsp_payload_type rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic                     pready,
   input  logic [3:0]               paddr,
   input  logic [31:0]              pwdata,
   output int                       fail_count,
   output int                       pending
);
   logic [31:0]                       key_p;
   logic [31:0]                       key_g;
   logic [31:0]                       key_y;
   logic [ebv_pkg::CountBits-1:0]     pairs_seen;
   logic                              verdict_so_far;
   ebv_pkg::rsp_payload_type          verdict_queue[$];

   // Exact modular product; both operands are below 2^32.
   function automatic logic [31:0] mod_mul(logic [31:0] a, logic [31:0] b, logic [31:0] m);
      return 32'((64'(a) * 64'(b)) % 64'(m));
   endfunction

   // Square-and-multiply exponentiation, modulus at least 3.
   function automatic logic [31:0] mod_pow(logic [31:0] base, logic [31:0] expo,
                                           logic [31:0] m);
      logic [31:0] acc;
      logic [31:0] b;
      logic [31:0] e;
      acc = 32'd1;
      b = base % m;
      e = expo;
      while (e != 0) begin
         if (e[0]) acc = mod_mul(acc, b, m);
         e = e >> 1;
         b = mod_mul(b, b, m);
      end
      return acc;
   endfunction

   // Works out the response for one accepted pair and advances the message state.
   function automatic ebv_pkg::rsp_payload_type verdict_of(ebv_pkg::req_payload_type d);
      ebv_pkg::rsp_payload_type v;
      logic            ok;
      logic [31:0]     lhs;
      logic [31:0]     rhs;
      ok = 1'b0;
      if (key_p >= 3 && d.sig_r > 0 && d.sig_r < key_p && d.sig_s > 0
          && d.sig_s < key_p - 1) begin
         lhs = mod_pow(key_g, 32'(d.digest_byte), key_p);
         rhs = mod_mul(mod_pow(key_y, d.sig_r, key_p), mod_pow(d.sig_r, d.sig_s, key_p),
                       key_p);
         ok = (lhs == rhs);
      end
      if (pairs_seen < ebv_pkg::CountMax) pairs_seen = pairs_seen + 1'b1;
      verdict_so_far = verdict_so_far & ok;
      v.pair_ok = ok;
      v.all_ok = verdict_so_far;
      v.final_res = d.last_pair;
      if (d.last_pair) begin
         v.all_ok = verdict_so_far &&
                    (pairs_seen == ebv_pkg::CountBits'(ebv_pkg::DigestBytes));
         pairs_seen = '0;
         verdict_so_far = 1'b1;
      end
      return v;
   endfunction

   assign pending = verdict_queue.size();

   // Register writes, request prediction and response comparison on each edge.
   always @(posedge clock) begin
      ebv_pkg::rsp_payload_type want;
      if (reset) begin
         key_p <= ebv_pkg::ModulusReset;
         key_g <= ebv_pkg::GeneratorReset;
         key_y <= ebv_pkg::PublicReset;
         pairs_seen = '0;
         verdict_so_far = 1'b1;
         fail_count <= 0;
         verdict_queue.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               ebv_pkg::RegModulus:   key_p <= pwdata;
               ebv_pkg::RegGenerator: key_g <= pwdata;
               ebv_pkg::RegPublic:    key_y <= pwdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            verdict_queue.insert(verdict_queue.size(), verdict_of(req_data));
         if (rsp_valid && rsp_ready) begin
            if (verdict_queue.size() == 0) begin
               if (fail_count < 10) $display("Unexpected response transfer %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = verdict_queue.pop_front();
               if (want != rsp_data) begin
                  if (fail_count < 10)
                     $display("Response mismatch: expected %p, got %p", want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

>>> verif/elgamal_byte_verifier_top_tb.sv
// Testbench top for the byte-wise signature verifier: clock, reset, key writes,
// signed and broken digest streams, response back-pressure and the verdict.
// Depends on ebv_pkg, elgamal_byte_verifier_top and elgamal_byte_verifier_checker.
`timescale 1ns / 1ps
module elgamal_byte_verifier_top_tb;
   localparam int CycleLimit = 20000000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   ebv_pkg::req_payload_type req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   ebv_pkg::rsp_payload_type rsp_data;
   logic            psel;
   logic            penable;
   logic            pwrite;
   logic [3:0]      paddr;
   logic [31:0]     pwdata;
   logic [31:0]     prdata;
   logic            pready;
   int              fail_count;
   int              pending;
   int              cycles;
   int              items_sent;
   int              snd_idle;
   int              rcv_idle;
   logic            hold_go;
   logic            hold_active;
   logic [31:0]     cur_p;
   logic [31:0]     cur_g;
   logic [31:0]     cur_x;
   logic            can_sign;

   elgamal_byte_verifier_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   elgamal_byte_verifier_checker u_chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
   );

   // Clock with a 20 ns period.
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog: a run that overstays the limit fails.
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   // Receiver readiness: random stalls, overridden by the long hold-off.
   always @(posedge clock) begin
      if (reset || hold_active) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= rcv_idle);
   end

   // Long receiver hold-off, counted here while the sender keeps offering.
   // It spans several slow items, so the block fills and holds off its input.
   initial begin
      hold_active = 1'b0;
      wait (hold_go);
      @(posedge clock);
      hold_active <= 1'b1;
      repeat (20000) @(posedge clock);
      hold_active <= 1'b0;
   end

   // Modular inverse by the extended Euclidean algorithm; 0 when none exists.
   function automatic longint unsigned inverse_mod(longint unsigned k, longint unsigned n);
      longint t0;
      longint t1;
      longint r0;
      longint r1;
      longint q;
      longint tmp;
      t0 = 0; t1 = 1; r0 = n; r1 = k;
      while (r1 != 0) begin
         q = r0 / r1;
         tmp = t0 - q * t1; t0 = t1; t1 = tmp;
         tmp = r0 - q * r1; r0 = r1; r1 = tmp;
      end
      if (r0 != 1) return 0;
      if (t0 < 0) t0 = t0 + n;
      return t0;
   endfunction

   // Configuration write: setup cycle, then access cycle.
   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {index, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   // One request transfer, preceded by a random idle gap.
   task automatic send(logic [7:0] m, logic [31:0] r, logic [31:0] s, logic last);
      ebv_pkg::req_payload_type d;
      int              gap;
      gap = ($urandom_range(99) < snd_idle) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      d.digest_byte = m;
      d.sig_r = r;
      d.sig_s = s;
      d.last_pair = last;
      req_data <= d;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // A pair signed with the current key, or random values when asked or unsignable.
   task automatic send_pair(logic [7:0] m, bit good, logic last);
      longint unsigned n;
      longint unsigned k;
      longint unsigned kinv;
      longint unsigned r;
      longint unsigned s;
      int              tries;
      n = longint'(cur_p) - 1;
      s = 0;
      if (good && can_sign) begin
         for (tries = 0; tries < 100 && s == 0; tries++) begin
            k = $urandom_range(1, 32'(n - 1));
            kinv = inverse_mod(k, n);
            if (kinv != 0) begin
               r = u_chk.mod_pow(cur_g, 32'(k), cur_p);
               s = (m + n - (longint'(cur_x) * r) % n) % n;
               s = (s * kinv) % n;
            end
         end
      end
      if (s == 0) begin
         r = $urandom_range(1) ? $urandom() : $urandom_range(0, cur_p);
         s = $urandom_range(1) ? $urandom() : $urandom_range(0, cur_p);
      end else if ($urandom_range(9) == 0) begin
         // A signed pair presented with the wrong digest byte.
         m = m ^ 8'(1 << $urandom_range(7));
      end
      send(m, 32'(r), 32'(s), last);
   endtask

   // A message of the given length, closed by a last pair when asked.
   task automatic send_message(int len, bit closes);
      for (int i = 0; i < len; i++)
         send_pair(8'($urandom_range(255)), $urandom_range(99) < 92, closes && i == len - 1);
   endtask

   // Random traffic: mostly well-formed messages, some of odd length, some noise.
   task automatic random_traffic(int target, int max_len);
      int kind;
      while (items_sent < target) begin
         kind = $urandom_range(99);
         if (kind < 70)
            send_message(max_len >= ebv_pkg::DigestBytes ? ebv_pkg::DigestBytes
                                                         : $urandom_range(1, max_len), 1);
         else if (kind < 85)
            send_message($urandom_range(1, max_len), 1);
         else
            send_pair(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
      end
   endtask

   // Waits until every response has arrived and the block has settled.
   task automatic drain();
      @(posedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Installs a key; an unsignable key leaves the public value as written.
   task automatic set_key(logic [31:0] p, logic [31:0] g, logic [31:0] y, logic [31:0] x,
                          bit signable);
      cur_p = p; cur_g = g; cur_x = x; can_sign = signable;
      csr_write(ebv_pkg::RegModulus, p);
      csr_write(ebv_pkg::RegGenerator, g);
      csr_write(ebv_pkg::RegPublic, signable ? u_chk.mod_pow(g, x, p) : y);
   endtask

   // Stimulus: reset, then key phases with their own idle patterns.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_data = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      hold_go = 1'b0; items_sent = 0;
      snd_idle = 28; rcv_idle = 83;
      cur_p = ebv_pkg::ModulusReset; cur_g = ebv_pkg::GeneratorReset;
      cur_x = 0; can_sign = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset key (public value 1, so a zero secret): range edges and a short message.
      send_pair(8'd0, 1'b1, 1'b0);
      send_pair(8'd255, 1'b1, 1'b0);
      send(8'd5, 32'd0, 32'd7, 1'b0);
      send(8'd5, cur_p, 32'd7, 1'b0);
      send(8'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send(8'd5, 32'd3, 32'd0, 1'b0);
      send(8'd5, 32'd3, cur_p - 1, 1'b0);
      send(8'd9, 32'd1, cur_p - 2, 1'b0);
      send_pair(8'd200, 1'b1, 1'b1);
      // A message long enough to saturate the pair count.
      send_message(66, 1);
      random_traffic(130, 40);
      drain();

      // Largest 32-bit prime: slow items, so short messages only.
      set_key(32'd4294967291, 32'd2, 32'd0, $urandom_range(1, 32'hFFFF_FF00), 1'b1);
      random_traffic(142, 6);
      drain();

      snd_idle = 83; rcv_idle = 28;
      // Smallest legal modulus: no pair can pass.
      set_key(32'd3, 32'd2, 32'hFFFF_FFFF, 32'd0, 1'b0);
      random_traffic(157, 5);
      drain();

      // Degenerate modulus and extreme key values; an unmapped register write too.
      set_key(32'd2, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0);
      csr_write(2'd3, 32'hDEAD_BEEF);
      random_traffic(167, 5);
      drain();

      snd_idle = 0; rcv_idle = 0;
      set_key(32'd65521, 32'd17, 32'd0, $urandom_range(1, 65519), 1'b1);
      hold_go = 1'b1;
      random_traffic(290, 40);
      drain();

      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
